// ----- rtl/core/erld_pkg.sv -----
// Shared types and constants for the extent run list decoder.
package erld_pkg;

    localparam int unsigned RECORD_BYTES    = 1024;
    localparam int unsigned RECORD_SHIFT    = $clog2(RECORD_BYTES);
    localparam int unsigned MAX_FIELD_BYTES = 8;
    localparam int unsigned BPC_W           = 22;
    localparam int unsigned WORD_W          = 64;
    localparam int unsigned HALF_W          = WORD_W / 2;
    localparam logic [BPC_W-1:0] BPC_RESET  = BPC_W'(4096);

    typedef enum logic [1:0] {
        KIND_RUN       = 2'd0,
        KIND_END       = 2'd1,
        KIND_MALFORMED = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] run_length;
        logic [WORD_W-1:0] start_cluster;
    } t_run_res;

endpackage

// ----- rtl/core/erld_decode.sv -----
// Input register, run list parser state and decoded run register.
module erld_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_start,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output erld_pkg::t_run_res o_res
);
    import erld_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DELTA  = 2'd2
    } t_phase;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_start;

    t_phase            r_phase, n_phase;
    logic [3:0]        r_lw, n_lw;
    logic [3:0]        r_dw, n_dw;
    logic [3:0]        r_pos, n_pos;
    logic [WORD_W-1:0] r_len, n_len;
    logic [WORD_W-1:0] r_delta, n_delta;
    logic [WORD_W-1:0] r_cluster, n_cluster;
    logic              r_done, n_done;

    logic              r_res_valid;
    t_run_res          r_res;

    t_run_res          res;
    logic              produce;
    logic              s0_adv;
    logic              p1_ready;

    function automatic logic [WORD_W-1:0] sign_ext(input logic [WORD_W-1:0] v,
                                                   input logic [3:0] w);
        logic [WORD_W-1:0] r;
        begin
            r = v;
            case (w)
                4'd1: r = {{56{v[7]}},  v[7:0]};
                4'd2: r = {{48{v[15]}}, v[15:0]};
                4'd3: r = {{40{v[23]}}, v[23:0]};
                4'd4: r = {{32{v[31]}}, v[31:0]};
                4'd5: r = {{24{v[39]}}, v[39:0]};
                4'd6: r = {{16{v[47]}}, v[47:0]};
                4'd7: r = {{8{v[55]}},  v[55:0]};
                default: r = v;
            endcase
            return r;
        end
    endfunction

    always_comb begin
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] shifted;
        logic [WORD_W-1:0] fin_len;
        logic [WORD_W-1:0] fin_delta;
        logic              fin;
        t_phase            eff_phase;
        logic              eff_done;

        // A list start clears the running cluster before the byte is parsed.
        base      = r_in_start ? '0 : r_cluster;
        eff_phase = r_in_start ? PH_HEADER : r_phase;
        eff_done  = r_in_start ? 1'b0 : r_done;
        shifted   = {56'd0, r_in_byte} << {r_pos[2:0], 3'b000};

        n_phase   = eff_phase;
        n_lw      = r_lw;
        n_dw      = r_dw;
        n_pos     = r_pos;
        n_len     = r_len;
        n_delta   = r_delta;
        n_cluster = base;
        n_done    = eff_done;
        fin       = 1'b0;
        fin_len   = r_len;
        fin_delta = r_delta;
        produce   = 1'b0;
        res       = '{kind: KIND_RUN, run_length: '0, start_cluster: '0};

        if (!eff_done) begin
            case (eff_phase)
                PH_LENGTH: begin
                    n_len = r_len | shifted;
                    n_pos = r_pos + 4'd1;
                    if (n_pos >= r_lw) begin
                        if (r_dw == 4'd0) begin
                            fin     = 1'b1;
                            fin_len = n_len;
                        end else begin
                            n_phase = PH_DELTA;
                            n_pos   = 4'd0;
                        end
                    end
                end
                PH_DELTA: begin
                    n_delta = r_delta | shifted;
                    n_pos   = r_pos + 4'd1;
                    if (n_pos >= r_dw) begin
                        fin       = 1'b1;
                        fin_delta = n_delta;
                    end
                end
                default: begin
                    if (r_in_byte[3:0] == 4'd0) begin
                        n_done   = 1'b1;
                        produce  = 1'b1;
                        res.kind = KIND_END;
                    end else if ((32'(r_in_byte[3:0]) > MAX_FIELD_BYTES) ||
                                 (32'(r_in_byte[7:4]) > MAX_FIELD_BYTES)) begin
                        n_done   = 1'b1;
                        produce  = 1'b1;
                        res.kind = KIND_MALFORMED;
                    end else begin
                        n_lw    = r_in_byte[3:0];
                        n_dw    = r_in_byte[7:4];
                        n_pos   = 4'd0;
                        n_len   = '0;
                        n_delta = '0;
                        n_phase = PH_LENGTH;
                    end
                end
            endcase
        end

        if (fin) begin
            n_cluster         = base + sign_ext(fin_delta, r_dw);
            n_phase           = PH_HEADER;
            produce           = 1'b1;
            res.run_length    = fin_len;
            res.start_cluster = n_cluster;
        end
    end

    assign p1_ready    = !r_res_valid || i_res_ready;
    assign s0_adv      = r_in_valid && (!produce || p1_ready);
    assign o_ready     = !r_in_valid || s0_adv;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_phase     <= PH_HEADER;
            r_lw        <= '0;
            r_dw        <= '0;
            r_pos       <= '0;
            r_len       <= '0;
            r_delta     <= '0;
            r_cluster   <= '0;
            r_done      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (s0_adv) begin
                r_phase   <= n_phase;
                r_lw      <= n_lw;
                r_dw      <= n_dw;
                r_pos     <= n_pos;
                r_len     <= n_len;
                r_delta   <= n_delta;
                r_cluster <= n_cluster;
                r_done    <= n_done;
            end
            if (s0_adv && produce) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte  <= i_byte;
            r_in_start <= i_start;
        end
        if (s0_adv && produce) begin
            r_res <= res;
        end
    end

endmodule

// ----- rtl/core/erld_recs.sv -----
// Record count: split 64 by 22 bit product, then sum, shift and output register.
module erld_recs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [erld_pkg::BPC_W-1:0]    i_bpc,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  erld_pkg::t_run_res            i_res,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_kind,
    output logic [3*erld_pkg::WORD_W-1:0] o_data
);
    import erld_pkg::*;

    localparam int unsigned LO_W = HALF_W + BPC_W;

    logic              r_p2_valid;
    t_run_res          r_p2_res;
    logic [LO_W-1:0]   r_prod_lo;
    logic [HALF_W-1:0] r_prod_hi;

    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [WORD_W-1:0] r_out_len;
    logic [WORD_W-1:0] r_out_start;
    logic [WORD_W-1:0] r_out_recs;

    logic              out_ready;
    logic              p2_ready;
    logic [LO_W-1:0]   prod_lo;
    logic [LO_W-1:0]   prod_hi_full;
    logic [WORD_W-1:0] prod_sum;

    assign out_ready = !r_out_valid || i_ready;
    assign p2_ready  = !r_p2_valid || out_ready;
    assign o_ready   = p2_ready;

    // Each half of the length is multiplied separately; only the low word of
    // the upper partial product survives the wrap at 64 bits.
    assign prod_lo      = LO_W'(i_res.run_length[HALF_W-1:0]) * LO_W'(i_bpc);
    assign prod_hi_full = LO_W'(i_res.run_length[WORD_W-1:HALF_W]) * LO_W'(i_bpc);
    assign prod_sum     = WORD_W'(r_prod_lo) + {r_prod_hi, {HALF_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (p2_ready) begin
                r_p2_valid <= i_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_p2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p2_ready && i_valid) begin
            r_p2_res  <= i_res;
            r_prod_lo <= prod_lo;
            r_prod_hi <= prod_hi_full[HALF_W-1:0];
        end
        if (out_ready && r_p2_valid) begin
            r_out_kind  <= r_p2_res.kind;
            r_out_len   <= r_p2_res.run_length;
            r_out_start <= r_p2_res.start_cluster;
            r_out_recs  <= prod_sum >> RECORD_SHIFT;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_data  = {r_out_recs, r_out_start, r_out_len};

endmodule

// ----- rtl/core/extent_run_list_decoder.sv -----
// Top level of the extent run list decoder: config register and stream pipeline.
//
//   channel   dir  payload                                     beat
//   s_axis    in   tdata[7:0] byte, tuser[0] list start        one run list byte
//   m_axis    out  tdata run/start/records, tuser[1:0] kind    one decoded run
//   cfg       in   i_cfg_wdata[21:0] bytes per cluster         one register write
//
// One byte is taken every cycle unless an m_axis stall backs up to s_axis; a run
// that ends on a byte reaches m_axis through the input register, then the parser,
// product and sum registers.
// Reset is synchronous and active low; it sets bytes per cluster to 4096.
// Stalls on m_axis back up stage by stage, so empty stages keep s_axis open.
module extent_run_list_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [erld_pkg::BPC_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
    input  logic [0:0]                    s_axis_tuser,  // [0] list_start
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [63:0] run_length, [127:64] start_cluster, [191:128] record_count
    output logic [3*erld_pkg::WORD_W-1:0] m_axis_tdata,
    output logic [1:0]                    m_axis_tuser   // [1:0] kind
);
    import erld_pkg::*;

    logic [BPC_W-1:0] r_bpc;
    logic             run_valid;
    logic             run_ready;
    t_run_res         run_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc <= BPC_RESET;
        end else if (i_cfg_we) begin
            r_bpc <= i_cfg_wdata;
        end
    end

    erld_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_start     (s_axis_tuser[0]),
        .o_res_valid (run_valid),
        .i_res_ready (run_ready),
        .o_res       (run_res)
    );

    erld_recs u_recs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_bpc   (r_bpc),
        .i_valid (run_valid),
        .o_ready (run_ready),
        .i_res   (run_res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_data  (m_axis_tdata)
    );

endmodule

// ----- test/erld_run_checker.sv -----
// Checker for the extent run list decoder: watches both streams, predicts each run and compares.
`timescale 1ns / 1ps

module erld_run_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [erld_pkg::BPC_W-1:0]    i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
    input  logic [0:0]                    s_axis_tuser,  // [0] list_start
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [63:0] run_length, [127:64] start_cluster, [191:128] record_count
    input  logic [3*erld_pkg::WORD_W-1:0] m_axis_tdata,
    input  logic [1:0]                    m_axis_tuser,  // [1:0] kind
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_result_count
);
    import erld_pkg::*;

    typedef enum logic [1:0] {
        AWAIT_HEADER,
        READ_LENGTH,
        READ_DELTA
    } t_parse;

    typedef struct packed {
        t_kind             kind;
        logic [WORD_W-1:0] run_length;
        logic [WORD_W-1:0] start_cluster;
        logic [WORD_W-1:0] record_count;
    } t_run_item;

    t_run_item         runs_due[$];
    logic [BPC_W-1:0]  cluster_bytes;
    t_parse            parse;
    logic [3:0]        len_bytes;
    logic [3:0]        delta_bytes;
    logic [3:0]        byte_idx;
    logic [WORD_W-1:0] len_acc;
    logic [WORD_W-1:0] delta_acc;
    logic [WORD_W-1:0] cluster_base;
    logic              list_over;
    int                fails = 0;
    int                results_checked = 0;

    task automatic queue_run(input t_kind k, input logic [WORD_W-1:0] len,
                             input logic [WORD_W-1:0] start, input logic [WORD_W-1:0] recs);
        t_run_item item;
        item.kind          = k;
        item.run_length    = len;
        item.start_cluster = start;
        item.record_count  = recs;
        runs_due.push_back(item);
    endtask

    task automatic close_run();
        logic [WORD_W-1:0] delta;
        logic [WORD_W-1:0] product;
        delta = delta_acc;
        // Partial-width deltas are signed; a full eight-byte delta is taken as is.
        if (delta_bytes > 0 && delta_bytes < 8 && delta_acc[8*delta_bytes-1])
            delta = delta | ({WORD_W{1'b1}} << (8 * delta_bytes));
        cluster_base = cluster_base + delta;
        parse        = AWAIT_HEADER;
        product      = len_acc * WORD_W'(cluster_bytes);
        queue_run(KIND_RUN, len_acc, cluster_base, product / RECORD_BYTES);
    endtask

    task automatic decode_list_byte(input logic [7:0] b, input logic list_start);
        logic [3:0] lw;
        logic [3:0] dw;
        lw = b[3:0];
        dw = b[7:4];
        if (list_start) begin
            cluster_base = '0;
            list_over    = 1'b0;
            parse        = AWAIT_HEADER;
        end
        if (list_over)
            return;
        case (parse)
            READ_LENGTH: begin
                len_acc  = len_acc | (WORD_W'(b) << (8 * byte_idx[2:0]));
                byte_idx = byte_idx + 1;
                if (byte_idx >= len_bytes) begin
                    if (delta_bytes == 0) begin
                        close_run();
                    end else begin
                        parse    = READ_DELTA;
                        byte_idx = '0;
                    end
                end
            end
            READ_DELTA: begin
                delta_acc = delta_acc | (WORD_W'(b) << (8 * byte_idx[2:0]));
                byte_idx  = byte_idx + 1;
                if (byte_idx >= delta_bytes)
                    close_run();
            end
            default: begin
                if (lw == 0) begin
                    list_over = 1'b1;
                    queue_run(KIND_END, '0, '0, '0);
                end else if (lw > MAX_FIELD_BYTES || dw > MAX_FIELD_BYTES) begin
                    list_over = 1'b1;
                    queue_run(KIND_MALFORMED, '0, '0, '0);
                end else begin
                    len_bytes   = lw;
                    delta_bytes = dw;
                    byte_idx    = '0;
                    len_acc     = '0;
                    delta_acc   = '0;
                    parse       = READ_LENGTH;
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_run_item want;
        if (runs_due.size() == 0) begin
            $error("unexpected result beat: kind %0d", m_axis_tuser);
            fails++;
            return;
        end
        want = runs_due.pop_front();
        results_checked++;
        if (m_axis_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            fails++;
        end
        if (m_axis_tdata[63:0] !== want.run_length) begin
            $error("run_length: expected %0h, got %0h", want.run_length, m_axis_tdata[63:0]);
            fails++;
        end
        if (m_axis_tdata[127:64] !== want.start_cluster) begin
            $error("start_cluster: expected %0h, got %0h", want.start_cluster,
                   m_axis_tdata[127:64]);
            fails++;
        end
        if (m_axis_tdata[191:128] !== want.record_count) begin
            $error("record_count: expected %0h, got %0h", want.record_count,
                   m_axis_tdata[191:128]);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            runs_due.delete();
            cluster_bytes = BPC_RESET;
            parse         = AWAIT_HEADER;
            len_bytes     = '0;
            delta_bytes   = '0;
            byte_idx      = '0;
            len_acc       = '0;
            delta_acc     = '0;
            cluster_base  = '0;
            list_over     = 1'b0;
        end else begin
            // A result can never stem from a byte taken at the same edge, so check first.
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (i_cfg_we)
                cluster_bytes = i_cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                decode_list_byte(s_axis_tdata, s_axis_tuser[0]);
        end
        o_fail_count   <= fails;
        o_pending      <= runs_due.size();
        o_result_count <= results_checked;
    end

endmodule

// ----- test/tb.sv -----
// Testbench top for the extent run list decoder: stimulus, stall control and verdict.
`timescale 1ns / 1ps

module tb;
    import erld_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [BPC_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [3*WORD_W-1:0]   m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int fail_count;
    int pending;
    int result_count;
    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int hold_granted  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int bytes_sent    = 0;

    extent_run_list_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    erld_run_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_granted != hold_requests) begin
            hold_granted  <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("extent_run_list_decoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic list_start);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= list_start;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    // Stop offering bytes and wait until every predicted result has left the block.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cluster_bytes(input logic [BPC_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_run_list();
        int unsigned runs;
        int unsigned lw;
        int unsigned dw;
        int unsigned cut;
        logic        first;
        first = 1'b1;
        runs  = $urandom_range(0, 6);
        for (int r = 0; r < runs; r++) begin
            lw  = ($urandom_range(99) < 70) ? $urandom_range(1, 2) : $urandom_range(1, 8);
            dw  = $urandom_range(0, 8);
            // Now and then a list is abandoned in mid-run; the next list start drops it.
            cut = ($urandom_range(99) < 4) ? $urandom_range(0, lw + dw - 1) : lw + dw;
            send_byte({dw[3:0], lw[3:0]}, first);
            first = 1'b0;
            repeat (cut) send_byte(8'($urandom), 1'b0);
            if (cut < lw + dw)
                return;
        end
        case ($urandom_range(19))
            0, 1: begin
                if ($urandom_range(1))
                    send_byte({4'($urandom), 4'($urandom_range(9, 15))}, first);
                else
                    send_byte({4'($urandom_range(9, 15)), 4'($urandom_range(1, 8))}, first);
            end
            2: ;
            default: send_byte({4'($urandom), 4'h0}, first);
        endcase
        // Trailing bytes after the terminator are ignored by the block.
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
    endtask

    task automatic run_random_phase(input int unsigned byte_goal);
        int unsigned goal;
        goal = bytes_sent + byte_goal;
        while (bytes_sent < goal) begin
            if ($urandom_range(99) < 8)
                send_byte(8'($urandom), 1'($urandom));
            else
                send_run_list();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset cluster size.
        // A negative one-byte delta wraps the cluster number below zero.
        send_byte(8'h11, 1'b1);
        send_byte(8'h05, 1'b0);
        send_byte(8'h80, 1'b0);
        // A full eight-byte delta is used without extension.
        send_byte(8'h81, 1'b0);
        send_byte(8'hFF, 1'b0);
        repeat (7) send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        // No delta bytes: the run closes on its last length byte, here the longest length.
        send_byte(8'h08, 1'b0);
        repeat (8) send_byte(8'hFF, 1'b0);
        // End marker with a nonzero high nibble, then a byte that must be ignored.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h55, 1'b0);
        // Malformed length nibble, then malformed delta nibble, each opening a new list.
        send_byte(8'h19, 1'b1);
        send_byte(8'h91, 1'b1);
        // A new list starts in the middle of a run and opens with an end marker.
        send_byte(8'h21, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b1);

        write_cluster_bytes(BPC_W'(512));
        snd_idle_pct = 37;
        rcv_idle_pct <= 51;
        run_random_phase(250);
        // Long receiver hold-off while short runs keep coming, so the block fills and stalls.
        hold_requests <= hold_requests + 1;
        send_byte(8'h11, 1'b1);
        repeat (2) send_byte(8'($urandom), 1'b0);
        repeat (40) begin
            send_byte(8'h11, 1'b0);
            repeat (2) send_byte(8'($urandom), 1'b0);
        end
        run_random_phase(200);

        write_cluster_bytes(BPC_W'(2097152));
        snd_idle_pct = 51;
        rcv_idle_pct <= 37;
        run_random_phase(580);

        write_cluster_bytes(BPC_W'($urandom_range(512, 2097152)));
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        run_random_phase(560);

        drain();
        $display("Covered %0d run list bytes at four cluster sizes and three stall mixes;",
                 bytes_sent);
        $display("%0d decoded results were compared field by field.", result_count);
        if (fail_count == 0)
            $display("extent_run_list_decoder verification clean");
        else
            $display("extent_run_list_decoder verification failed");
        $finish;
    end

endmodule
